// ----- rtl/core/gtl_pkg.sv -----
// Package for the GBK text layout block: request and result structs,
// command codes, register indexes and layout constants.
// No dependencies; every other file in rtl/core imports it.
package gtl_pkg;

    // layout geometry
    localparam int ASCII_W   = 8;
    localparam int GBK_W     = 16;
    localparam int LINE_H    = 16;
    localparam int SUM_BITS  = 17;   // coordinate or register plus a cell, no overflow
    localparam int GLYPH_SHIFT = 5;  // 32-byte glyphs

    // byte classes
    localparam logic [7:0] BYTE_NUL   = 8'h00;
    localparam logic [7:0] BYTE_CR    = 8'd13;
    localparam logic [7:0] LEAD_MIN   = 8'h81;
    localparam logic [7:0] LEAD_LIMIT = 8'h80;
    localparam logic [7:0] TRAIL_MIN  = 8'h40;
    localparam logic [7:0] TRAIL_GAP  = 8'h7F;
    localparam logic [7:0] TRAIL_HI   = 8'h41;
    localparam logic [7:0] BYTE_FF    = 8'hFF;
    localparam logic [7:0] TRAILS_PER_LEAD = 8'd190;

    // configuration register indexes
    localparam int CFG_IDX_BITS = 3;
    localparam logic [CFG_IDX_BITS-1:0] REG_AREA_LEFT   = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_AREA_TOP    = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_AREA_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_AREA_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_DRAW_COLOR  = 3'd4;

    localparam logic [15:0] AREA_SIZE_RESET = 16'd240;

    // small queues between parts
    localparam int FIFO_DEPTH    = 2;
    localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);

    typedef enum logic [1:0] {
        OP_ASCII = 2'd0,
        OP_CR    = 2'd1,
        OP_GBK   = 2'd2
    } op_t;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       string_start;
    } in_item_t;

    typedef struct packed {
        logic        cell_kind;
        logic [15:0] pos_x;
        logic [15:0] pos_y;
        logic [15:0] char_code;
        logic [19:0] font_offset;
        logic        offset_valid;
        logic [15:0] pixel_color;
    } out_item_t;

    // command from the front part to the back part
    typedef struct packed {
        logic        start;
        op_t         op;
        logic [15:0] code;
        logic [19:0] font_offset;
        logic        offset_valid;
    } cmd_t;

    typedef struct packed {
        logic [15:0] area_left;
        logic [15:0] area_top;
        logic [15:0] area_width;
        logic [15:0] area_height;
        logic [15:0] draw_color;
    } cfg_t;

endpackage

// ----- rtl/core/gtl_fifo.sv -----
// Two-entry register queue used between the front and back parts and on
// the result side. Depends on gtl_pkg for the depth constants.
module gtl_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);
    import gtl_pkg::*;

    logic [WIDTH-1:0]         mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_PTR_BITS:0]   count_reg, count_next;
    logic                     do_push, do_pop;

    assign full    = (count_reg == (FIFO_PTR_BITS+1)'(FIFO_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// ----- rtl/core/gtl_front.sv -----
// Front part: takes string bytes, tracks lead, skip and end-of-string
// state, and turns each byte into a layout command. Depends on gtl_pkg.
module gtl_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  gtl_pkg::in_item_t text,
    output logic              cmd_push,
    output gtl_pkg::cmd_t     cmd
);
    import gtl_pkg::*;

    logic       done_reg, done_next;
    logic       pend_reg, pend_next;
    logic       skip_reg, skip_next;
    logic       start_reg, start_next;
    logic [7:0] lead_reg, lead_next;

    logic        done_v, pend_v, skip_v, start_v;
    logic [7:0]  b;
    logic [7:0]  trail_idx;
    logic [6:0]  lead_idx;
    logic [14:0] glyph_idx;
    logic        code_ok;

    assign b = text.text_byte;

    // GBK offset: (lead - 0x81) * 190 + trail index, in 32-byte glyphs
    always_comb
    begin
        code_ok   = !(b < TRAIL_MIN || b == BYTE_FF || lead_reg == BYTE_FF
                      || lead_reg < LEAD_MIN);
        trail_idx = (b < TRAIL_GAP) ? b - TRAIL_MIN : b - TRAIL_HI;
        lead_idx  = 7'(lead_reg - LEAD_MIN);
        glyph_idx = (15'(lead_idx) * 15'(TRAILS_PER_LEAD)) + 15'(trail_idx);
    end

    always_comb
    begin
        done_v  = done_reg;
        pend_v  = pend_reg;
        skip_v  = skip_reg;
        start_v = start_reg;
        if (text.string_start)
        begin
            done_v  = 1'b0;
            pend_v  = 1'b0;
            skip_v  = 1'b0;
            start_v = 1'b1;
        end

        done_next  = done_reg;
        pend_next  = pend_reg;
        skip_next  = skip_reg;
        start_next = start_reg;
        lead_next  = lead_reg;
        cmd_push   = 1'b0;
        cmd.start        = start_v;
        cmd.op           = OP_ASCII;
        cmd.code         = {8'h00, b};
        cmd.font_offset  = '0;
        cmd.offset_valid = 1'b0;

        if (accept)
        begin
            done_next  = done_v;
            pend_next  = pend_v;
            skip_next  = skip_v;
            start_next = start_v;
            if (!done_v)
            begin
                if (b == BYTE_NUL)
                begin
                    done_next  = 1'b1;
                    pend_next  = 1'b0;
                    skip_next  = 1'b0;
                    start_next = 1'b0;
                end
                else if (skip_v)
                begin
                    skip_next = 1'b0;
                end
                else if (pend_v)
                begin
                    pend_next  = 1'b0;
                    start_next = 1'b0;
                    cmd_push   = 1'b1;
                    cmd.op     = OP_GBK;
                    cmd.code   = {lead_reg, b};
                    if (code_ok)
                    begin
                        cmd.font_offset  = 20'(glyph_idx) << GLYPH_SHIFT;
                        cmd.offset_valid = 1'b1;
                    end
                end
                else if (b > LEAD_LIMIT)
                begin
                    pend_next = 1'b1;
                    lead_next = b;
                end
                else
                begin
                    start_next = 1'b0;
                    cmd_push   = 1'b1;
                    if (b == BYTE_CR)
                    begin
                        cmd.op    = OP_CR;
                        skip_next = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg  <= 1'b1;
            pend_reg  <= 1'b0;
            skip_reg  <= 1'b0;
            start_reg <= 1'b0;
            lead_reg  <= '0;
        end
        else
        begin
            done_reg  <= done_next;
            pend_reg  <= pend_next;
            skip_reg  <= skip_next;
            start_reg <= start_next;
            lead_reg  <= lead_next;
        end
    end

endmodule

// ----- rtl/core/gtl_back.sv -----
// Back part: owns the cursor, applies right-edge wrap and bottom-edge end,
// and builds the result for each command. Depends on gtl_pkg.
module gtl_back #(
    parameter int COORD_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  gtl_pkg::cfg_t      cfg,
    input  logic               cmd_valid,
    input  gtl_pkg::cmd_t      cmd,
    output logic               cmd_pop,
    input  logic               out_full,
    output logic               out_push,
    output gtl_pkg::out_item_t out_item
);
    import gtl_pkg::*;

    logic [COORD_BITS-1:0] cx_reg, cx_next;
    logic [COORD_BITS-1:0] cy_reg, cy_next;
    logic                  ended_reg, ended_next;

    logic                  take;
    logic [COORD_BITS-1:0] left, top, cx, cy, cx1, cy1, cell_w;
    logic                  ended, wrap, bottom;

    assign take    = cmd_valid && !out_full;
    assign cmd_pop = take;

    always_comb
    begin
        left   = cfg.area_left[COORD_BITS-1:0];
        top    = cfg.area_top[COORD_BITS-1:0];
        cx     = cmd.start ? left : cx_reg;
        cy     = cmd.start ? top  : cy_reg;
        ended  = cmd.start ? 1'b0 : ended_reg;
        cell_w = (cmd.op == OP_GBK) ? COORD_BITS'(GBK_W) : COORD_BITS'(ASCII_W);
        wrap   = (SUM_BITS'(cx) + SUM_BITS'(cell_w))
                 > (SUM_BITS'(left) + SUM_BITS'(cfg.area_width));
        cx1    = wrap ? left : cx;
        cy1    = wrap ? cy + COORD_BITS'(LINE_H) : cy;
        bottom = (SUM_BITS'(cy1) + SUM_BITS'(LINE_H))
                 > (SUM_BITS'(top) + SUM_BITS'(cfg.area_height));

        cx_next    = cx_reg;
        cy_next    = cy_reg;
        ended_next = ended_reg;
        out_push   = 1'b0;

        if (take)
        begin
            cx_next    = cx;
            cy_next    = cy;
            ended_next = ended;
            if (!ended)
            begin
                if (bottom)
                begin
                    ended_next = 1'b1;
                end
                else
                begin
                    case (cmd.op)
                        OP_CR:
                        begin
                            // new line, then step one ASCII cell in
                            cy_next = cy1 + COORD_BITS'(LINE_H);
                            cx_next = left + COORD_BITS'(ASCII_W);
                        end
                        OP_ASCII, OP_GBK:
                        begin
                            out_push = 1'b1;
                            cx_next  = cx1 + cell_w;
                            cy_next  = cy1;
                        end
                        default:
                        begin
                            out_push = 1'b0;
                        end
                    endcase
                end
            end
        end

        out_item.cell_kind    = (cmd.op == OP_GBK);
        out_item.pos_x        = 16'(cx1);
        out_item.pos_y        = 16'(cy1);
        out_item.char_code    = cmd.code;
        out_item.font_offset  = cmd.font_offset;
        out_item.offset_valid = cmd.offset_valid;
        out_item.pixel_color  = cfg.draw_color;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cx_reg    <= '0;
            cy_reg    <= '0;
            ended_reg <= 1'b0;
        end
        else
        begin
            cx_reg    <= cx_next;
            cy_reg    <= cy_next;
            ended_reg <= ended_next;
        end
    end

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        out_push |-> !out_full)
        else $error("result pushed into a full queue");

    a_ended_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (ended_reg && !cmd.start) |-> !out_push)
        else $error("result after the string ended");

    a_ascii_no_offset: assert property (@(posedge clk) disable iff (!rst_n)
        (out_push && !out_item.cell_kind)
        |-> (!out_item.offset_valid && out_item.font_offset == '0))
        else $error("ASCII cell carries a font offset");

    a_offset_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        (out_push && out_item.offset_valid) |-> (out_item.font_offset[4:0] == '0))
        else $error("font offset not glyph aligned");

endmodule

// ----- rtl/core/gbk_text_layout.sv -----
// Top level of the GBK text layout block: configuration registers, front
// part, command queue, back part and result queue.
// Depends on gtl_pkg, gtl_fifo, gtl_front and gtl_back.
//
//  channel   handshake                    payload
//  -------   ---------------------------  ---------------------------
//  text      push / full                  gtl_pkg::in_item_t
//  glyph     empty / pop                  gtl_pkg::out_item_t
//  cfg       cfg_valid / cfg_ready        cfg_index, cfg_data
//
// One byte per cycle while full is low; the back part handles one command
// a cycle while the result queue has room. Results pass through both
// queues. full rises only when the two-entry command queue fills, which
// happens when pop stays low and the two-entry result queue is full.
// Reset leaves the block idle until a byte with string_start; cfg_ready
// stays high and registers take their reset values at once.
module gbk_text_layout #(
    parameter int COORD_BITS = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    output logic                        full,
    input  gtl_pkg::in_item_t           text,
    output logic                        empty,
    input  logic                        pop,
    output gtl_pkg::out_item_t          glyph,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [gtl_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [15:0]                 cfg_data
);
    import gtl_pkg::*;

    cfg_t      cfg_reg, cfg_next;
    logic      accept;
    logic      cmd_push, cmd_full, cmd_empty, cmd_pop;
    cmd_t      front_cmd, back_cmd;
    logic [$bits(cmd_t)-1:0]      cmd_wdata, cmd_rdata;
    logic      res_push, res_full;
    out_item_t res_item;
    logic [$bits(out_item_t)-1:0] res_wdata, res_rdata;

    assign cfg_ready = 1'b1;
    assign accept    = push && !full;
    assign full      = cmd_full;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_AREA_LEFT:   cfg_next.area_left   = cfg_data;
                REG_AREA_TOP:    cfg_next.area_top    = cfg_data;
                REG_AREA_WIDTH:  cfg_next.area_width  = cfg_data;
                REG_AREA_HEIGHT: cfg_next.area_height = cfg_data;
                REG_DRAW_COLOR:  cfg_next.draw_color  = cfg_data;
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.area_left   <= '0;
            cfg_reg.area_top    <= '0;
            cfg_reg.area_width  <= AREA_SIZE_RESET;
            cfg_reg.area_height <= AREA_SIZE_RESET;
            cfg_reg.draw_color  <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    gtl_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .text     (text),
        .cmd_push (cmd_push),
        .cmd      (front_cmd)
    );

    assign cmd_wdata = front_cmd;
    assign back_cmd  = cmd_t'(cmd_rdata);

    gtl_fifo #(
        .WIDTH ($bits(cmd_t))
    ) u_cmd_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (cmd_push),
        .wdata (cmd_wdata),
        .full  (cmd_full),
        .pop   (cmd_pop),
        .rdata (cmd_rdata),
        .empty (cmd_empty)
    );

    gtl_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cmd_valid (!cmd_empty),
        .cmd       (back_cmd),
        .cmd_pop   (cmd_pop),
        .out_full  (res_full),
        .out_push  (res_push),
        .out_item  (res_item)
    );

    assign res_wdata = res_item;
    assign glyph     = out_item_t'(res_rdata);

    gtl_fifo #(
        .WIDTH ($bits(out_item_t))
    ) u_res_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res_wdata),
        .full  (res_full),
        .pop   (pop),
        .rdata (res_rdata),
        .empty (empty)
    );

endmodule

// ----- bench/gbk_text_layout_test.sv -----
// Testbench for gbk_text_layout: a directed table, then random strings under
// several box settings, checked against an in-bench layout predictor.
// Depends on gtl_pkg and the gbk_text_layout RTL.
`timescale 1ns / 100ps

module gbk_text_layout_test;

    import gtl_pkg::*;

    localparam int RANDOM_BYTES = 1120;
    localparam int PHASE_BYTES  = 150;
    localparam int SETTLE_CYCLES = 8;
    localparam int MAX_REPORTS  = 40;

    localparam logic KIND_ASCII = 1'b0;
    localparam logic KIND_GBK   = 1'b1;

    typedef enum int {
        PACE_STEADY,
        PACE_RANDOM,
        PACE_BURSTY
    } pace_t;

    typedef struct {
        logic [7:0] b;
        logic       st;
        bit         typed;
        out_item_t  g;
    } dir_row_t;

    logic      clk;
    logic      rst_n = 1'b0;
    logic      push = 1'b0;
    logic      full;
    in_item_t  text = '0;
    logic      empty;
    logic      pop = 1'b0;
    out_item_t glyph;
    logic      cfg_valid = 1'b0;
    logic      cfg_ready;
    logic [CFG_IDX_BITS-1:0] cfg_index = '0;
    logic [15:0] cfg_data = '0;

    gbk_text_layout dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .text      (text),
        .empty     (empty),
        .pop       (pop),
        .glyph     (glyph),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // layout state kept by the bench, starting from reset values
    logic [15:0] box_left = '0;
    logic [15:0] box_top = '0;
    logic [15:0] box_width = AREA_SIZE_RESET;
    logic [15:0] box_height = AREA_SIZE_RESET;
    logic [15:0] box_color = '0;
    logic [15:0] cur_x = '0;
    logic [15:0] cur_y = '0;
    bit          lead_held = 1'b0;
    logic [7:0]  held_lead = '0;
    bit          skip_byte = 1'b0;
    bit          text_over = 1'b1;

    out_item_t expected_glyphs[$];
    dir_row_t  dir_rows[$];

    int    bytes_pushed = 0;
    int    live_bytes = 0;
    int    glyphs_checked = 0;
    int    mismatches = 0;
    int    box_settings = 0;
    pace_t push_pace = PACE_STEADY;
    pace_t pop_pace = PACE_STEADY;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #5ms;
        $display("timeout with %0d glyphs still expected", expected_glyphs.size());
        $display("TEST FAILED");
        $finish;
    end

    function automatic void next_line();
        cur_y = cur_y + 16'(LINE_H);
        cur_x = box_left;
    endfunction

    // Wrap at the right edge, then stop the string at the bottom edge.
    function automatic bit fits_cell(input int unsigned w);
        if (32'(cur_x) + w > 32'(box_left) + 32'(box_width))
            next_line();
        if (32'(cur_y) + LINE_H > 32'(box_top) + 32'(box_height))
        begin
            text_over = 1'b1;
            return 1'b0;
        end
        return 1'b1;
    endfunction

    // Advance the layout by one byte; returns 1 when a glyph command results.
    function automatic bit layout_byte(input logic [7:0] b, input logic st,
                                       output out_item_t g, output bit live);
        int unsigned idx;
        g = '0;
        live = 1'b0;
        if (st)
        begin
            cur_x = box_left;
            cur_y = box_top;
            lead_held = 1'b0;
            skip_byte = 1'b0;
            text_over = 1'b0;
        end
        if (text_over)
            return 1'b0;
        live = 1'b1;
        if (b == BYTE_NUL)
        begin
            text_over = 1'b1;
            lead_held = 1'b0;
            skip_byte = 1'b0;
            return 1'b0;
        end
        if (skip_byte)
        begin
            skip_byte = 1'b0;
            return 1'b0;
        end
        if (lead_held)
        begin
            lead_held = 1'b0;
            if (!fits_cell(GBK_W))
                return 1'b0;
            g.cell_kind = KIND_GBK;
            g.pos_x = cur_x;
            g.pos_y = cur_y;
            g.char_code = {held_lead, b};
            g.pixel_color = box_color;
            if (b >= TRAIL_MIN && b != BYTE_FF && held_lead != BYTE_FF && held_lead >= LEAD_MIN)
            begin
                // the trail range skips 0x7F
                idx = (b < TRAIL_GAP) ? 32'(b) - 32'(TRAIL_MIN) : 32'(b) - 32'(TRAIL_HI);
                g.font_offset = 20'((((32'(held_lead) - 32'(LEAD_MIN)) * 32'(TRAILS_PER_LEAD))
                                     + idx) << GLYPH_SHIFT);
                g.offset_valid = 1'b1;
            end
            cur_x = cur_x + 16'(GBK_W);
            return 1'b1;
        end
        if (b > LEAD_LIMIT)
        begin
            lead_held = 1'b1;
            held_lead = b;
            return 1'b0;
        end
        if (!fits_cell(ASCII_W))
            return 1'b0;
        if (b == BYTE_CR)
        begin
            // new line starts one ASCII cell in; drop the byte after
            next_line();
            skip_byte = 1'b1;
            cur_x = cur_x + 16'(ASCII_W);
            return 1'b0;
        end
        g.cell_kind = KIND_ASCII;
        g.pos_x = cur_x;
        g.pos_y = cur_y;
        g.char_code = {8'h00, b};
        g.pixel_color = box_color;
        cur_x = cur_x + 16'(ASCII_W);
        return 1'b1;
    endfunction

    function automatic int unsigned draw_wait(input pace_t pace);
        case (pace)
            PACE_STEADY: return 0;
            PACE_RANDOM: return $urandom_range(0, 15);
            default:     return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : 0;
        endcase
    endfunction

    // draw color is still at its reset value in the directed table
    function automatic out_item_t ascii_cell(input logic [15:0] x, input logic [15:0] y,
                                             input logic [7:0] code);
        out_item_t g;
        g = '0;
        g.cell_kind = KIND_ASCII;
        g.pos_x = x;
        g.pos_y = y;
        g.char_code = {8'h00, code};
        return g;
    endfunction

    function automatic out_item_t gbk_cell(input logic [15:0] x, input logic [15:0] y,
                                           input logic [15:0] code, input logic [19:0] offset,
                                           input logic valid);
        out_item_t g;
        g = '0;
        g.cell_kind = KIND_GBK;
        g.pos_x = x;
        g.pos_y = y;
        g.char_code = code;
        g.font_offset = offset;
        g.offset_valid = valid;
        return g;
    endfunction

    function automatic dir_row_t row(input logic [7:0] b, input logic st,
                                     input bit typed = 1'b0, input out_item_t g = '0);
        dir_row_t r;
        r.b = b;
        r.st = st;
        r.typed = typed;
        r.g = g;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("[%0t] %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    endtask

    task automatic check_glyph(input out_item_t got);
        out_item_t want;
        if (expected_glyphs.size() == 0)
        begin
            report_mismatch("glyph with none expected, char_code", 32'(got.char_code), '0);
            return;
        end
        want = expected_glyphs.pop_front();
        glyphs_checked++;
        if (got.cell_kind !== want.cell_kind)
            report_mismatch("cell_kind", 32'(got.cell_kind), 32'(want.cell_kind));
        if (got.pos_x !== want.pos_x)
            report_mismatch("pos_x", 32'(got.pos_x), 32'(want.pos_x));
        if (got.pos_y !== want.pos_y)
            report_mismatch("pos_y", 32'(got.pos_y), 32'(want.pos_y));
        if (got.char_code !== want.char_code)
            report_mismatch("char_code", 32'(got.char_code), 32'(want.char_code));
        if (got.font_offset !== want.font_offset)
            report_mismatch("font_offset", 32'(got.font_offset), 32'(want.font_offset));
        if (got.offset_valid !== want.offset_valid)
            report_mismatch("offset_valid", 32'(got.offset_valid), 32'(want.offset_valid));
        if (got.pixel_color !== want.pixel_color)
            report_mismatch("pixel_color", 32'(got.pixel_color), 32'(want.pixel_color));
    endtask

    // Push one byte; hold push high across back-to-back requests.
    task automatic send_byte(input logic [7:0] b, input logic st,
                             input bit typed = 1'b0, input out_item_t typed_g = '0);
        int unsigned gap;
        out_item_t   g;
        bit          live;
        if (bytes_pushed % 32 == 0)
            push_pace = pace_t'($urandom_range(0, 2));
        gap = draw_wait(push_pace);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push <= 1'b1;
        text <= {b, st};
        do
            @(posedge clk);
        while (full);
        if (layout_byte(b, st, g, live))
            expected_glyphs.push_back(typed ? typed_g : g);
        if (live)
            live_bytes++;
        bytes_pushed++;
    endtask

    task automatic settle();
        push <= 1'b0;
        while (expected_glyphs.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic load_box(input logic [15:0] left, input logic [15:0] top,
                            input logic [15:0] width, input logic [15:0] height,
                            input logic [15:0] color);
        logic [CFG_IDX_BITS-1:0] regs [5];
        logic [15:0]             vals [5];
        regs = '{REG_AREA_LEFT, REG_AREA_TOP, REG_AREA_WIDTH, REG_AREA_HEIGHT,
                 REG_DRAW_COLOR};
        vals = '{left, top, width, height, color};
        cfg_valid <= 1'b1;
        for (int i = 0; i < 5; i++)
        begin
            cfg_index <= regs[i];
            cfg_data <= vals[i];
            do
                @(posedge clk);
            while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
        box_left = left;
        box_top = top;
        box_width = width;
        box_height = height;
        box_color = color;
        box_settings++;
    endtask

    task automatic set_box(input int phase);
        case (phase)
            0: load_box(16'd0, 16'd0, AREA_SIZE_RESET, AREA_SIZE_RESET, 16'($urandom));
            // cursor wraps past the top of the coordinate space
            1: load_box(16'hFFF0, 16'hFFF0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
            // empty box: every string ends at its first cell
            2: load_box(16'($urandom), 16'($urandom), 16'd0, 16'd0, 16'h0000);
            // narrower than a GBK cell: wrap before every GBK glyph
            3: load_box(16'd0, 16'd0, 16'd15, 16'd64, 16'h8421);
            4: load_box(16'($urandom_range(0, 16'h7FFF)), 16'($urandom_range(0, 16'h7FFF)),
                        16'd64, 16'd48, 16'($urandom));
            5: load_box(16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 16'h0000);
            default: load_box(16'($urandom), 16'($urandom), 16'($urandom_range(0, 320)),
                              16'($urandom_range(0, 320)), 16'($urandom));
        endcase
    endtask

    // One string of random tokens, mostly well formed.
    task automatic send_random_string();
        int tokens;
        int pick;
        bit first;
        if ($urandom_range(0, 9) == 0)
            repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0);
        tokens = $urandom_range(0, 24);
        first = 1'b1;
        for (int t = 0; t <= tokens; t++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
                send_byte(8'($urandom_range(1, 128)), first);
            else if (pick < 80)
            begin
                send_byte(8'($urandom_range(LEAD_MIN, 255)), first);
                if ($urandom_range(0, 9) != 0)
                    send_byte(8'($urandom_range(TRAIL_MIN, 8'hFE)), 1'b0);
                else
                    send_byte(8'($urandom_range(1, 255)), 1'b0);
            end
            else if (pick < 90)
            begin
                send_byte(BYTE_CR, first);
                send_byte(8'($urandom_range(1, 255)), 1'b0);
            end
            else if (pick < 95)
                send_byte(BYTE_NUL, first);
            else
            begin
                send_byte(8'($urandom_range(LEAD_MIN, 255)), first);
                send_byte(BYTE_NUL, 1'b0);
            end
            first = 1'b0;
        end
        pick = $urandom_range(0, 9);
        if (pick < 8)
            send_byte(BYTE_NUL, 1'b0);
        else if (pick == 8)
            send_byte(8'($urandom_range(LEAD_MIN, 255)), 1'b0);
    endtask

    // result side: random stalls on pop, check every accepted glyph
    initial
    begin
        int unsigned stall;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (glyphs_checked % 32 == 0)
                pop_pace = pace_t'($urandom_range(0, 2));
            stall = draw_wait(pop_pace);
            if (stall > 0)
            begin
                pop <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            pop <= 1'b1;
            do
                @(posedge clk);
            while (empty);
            check_glyph(glyph);
        end
    end

    initial
    begin
        int phase;
        int phase_mark;
        int random_base;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows under the reset box: 240x240 at the origin, color 0
        dir_rows.push_back(row(8'h41, 1'b0));
        dir_rows.push_back(row(8'h41, 1'b1, 1'b1, ascii_cell(16'd0, 16'd0, 8'h41)));
        dir_rows.push_back(row(8'h81, 1'b0));
        dir_rows.push_back(row(8'h40, 1'b0, 1'b1,
                               gbk_cell(16'd8, 16'd0, 16'h8140, 20'd0, 1'b1)));
        dir_rows.push_back(row(8'hFE, 1'b0));
        dir_rows.push_back(row(8'hFE, 1'b0, 1'b1,
                               gbk_cell(16'd24, 16'd0, 16'hFEFE, 20'd766048, 1'b1)));
        dir_rows.push_back(row(8'hFF, 1'b0));
        dir_rows.push_back(row(8'h80, 1'b0, 1'b1,
                               gbk_cell(16'd40, 16'd0, 16'hFF80, 20'd0, 1'b0)));
        dir_rows.push_back(row(8'h81, 1'b0));
        dir_rows.push_back(row(8'h3F, 1'b0, 1'b1,
                               gbk_cell(16'd56, 16'd0, 16'h813F, 20'd0, 1'b0)));
        dir_rows.push_back(row(8'h81, 1'b0));
        dir_rows.push_back(row(8'h7F, 1'b0));
        dir_rows.push_back(row(8'h80, 1'b0));
        dir_rows.push_back(row(BYTE_CR, 1'b0));
        dir_rows.push_back(row(8'h5A, 1'b0));
        dir_rows.push_back(row(8'h01, 1'b0));
        dir_rows.push_back(row(8'h85, 1'b0));
        dir_rows.push_back(row(BYTE_NUL, 1'b0));
        dir_rows.push_back(row(8'h41, 1'b0));
        dir_rows.push_back(row(8'h7F, 1'b1, 1'b1, ascii_cell(16'd0, 16'd0, 8'h7F)));
        dir_rows.push_back(row(BYTE_CR, 1'b0));
        dir_rows.push_back(row(BYTE_NUL, 1'b0));
        dir_rows.push_back(row(8'hFF, 1'b1));
        dir_rows.push_back(row(8'hFF, 1'b0, 1'b1,
                               gbk_cell(16'd0, 16'd0, 16'hFFFF, 20'd0, 1'b0)));
        dir_rows.push_back(row(BYTE_NUL, 1'b0));
        foreach (dir_rows[i])
            send_byte(dir_rows[i].b, dir_rows[i].st, dir_rows[i].typed, dir_rows[i].g);
        settle();

        random_base = bytes_pushed;
        phase = 0;
        set_box(phase);
        phase_mark = bytes_pushed;
        while (bytes_pushed - random_base < RANDOM_BYTES)
        begin
            if (bytes_pushed - phase_mark >= PHASE_BYTES)
            begin
                settle();
                phase++;
                set_box(phase);
                phase_mark = bytes_pushed;
            end
            send_random_string();
        end
        settle();

        $display("Pushed %0d bytes (%0d inside live strings) over %0d box settings;",
                 bytes_pushed, live_bytes, box_settings);
        $display("checked %0d glyph commands, %0d field mismatches.",
                 glyphs_checked, mismatches);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/gtl_pkg.sv
rtl/core/gtl_fifo.sv
rtl/core/gtl_front.sv
rtl/core/gtl_back.sv
rtl/core/gbk_text_layout.sv
bench/gbk_text_layout_test.sv
